// File: rtl/core/bsa_pkg.sv
// Shared codes and constants of the bitmap slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned DIV_ITER  = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_MISALIGNED = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_OBJ_SIZE = 2'd1;
  localparam logic [1:0] REG_BASE     = 2'd2;

  localparam logic [8:0]  CAPACITY_RST = 9'd256;
  localparam logic [15:0] OBJ_SIZE_RST = 16'd1;
  localparam logic [31:0] BASE_RST     = 32'd0;

endpackage

// File: rtl/core/bitmap_slot_allocator.sv
// Slot pool allocator over an occupancy bitmap, with serial address-to-slot division.
`timescale 1ns / 1ps

// One request at a time. An allocate reads the bitmap one 32-bit word at a time, in a read
// and a check state, from word 0 up to the first word holding a free slot below the
// capacity in use, then takes a multiply step and an add step to form the slot address.
// A free runs offset / object_size through a restoring divider that retires two
// quotient bits per cycle (a zero object_size skips it), then checks alignment and
// range and clears the bit with one read-modify-write of the bitmap memory. The
// result sits in an output register, so the next request is accepted while it waits.
// The bitmap needs no clearing pass after reset: a per-word valid bit makes a
// never-written word read as all free.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // object_address
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status, slot_index, slot_address, zero pad
);

  localparam int unsigned WORD_COUNT = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned SLOT_W     = WIDX_W + 5;
  localparam int unsigned CMP_W      = ((SLOT_W > 9) ? SLOT_W : 9) + 1;
  localparam int unsigned PROD_W     = SLOT_W + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_MUL, S_A_ADD,
    S_F_DIV, S_F_RNG, S_F_RD, S_F_WR, S_DONE
  } state_e;

  state_e              state_q;
  logic [8:0]          cap_q;
  logic [15:0]         size_q;
  logic [31:0]         base_q;
  logic [WORD_COUNT-1:0] word_vld_q;
  logic [31:0]         mem_q [WORD_COUNT];
  logic [31:0]         rd_word_q;
  logic                rd_vld_q;
  logic [WIDX_W-1:0]   word_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [PROD_W-1:0]   prod_q;
  logic [31:0]         addr_q;
  logic [31:0]         dq_q;
  logic [15:0]         rem_q;
  logic [3:0]          cnt_q;
  logic [1:0]          res_status_q;
  logic [7:0]          res_index_q;
  logic [31:0]         res_addr_q;
  logic                out_vld_q;
  logic [1:0]          out_status_q;
  logic [7:0]          out_index_q;
  logic [31:0]         out_addr_q;

  logic [CMP_W-1:0]    live_cap;
  logic [CMP_W-1:0]    next_base;
  logic [31:0]         cur_word;
  logic                zero_found;
  logic [4:0]          zero_bit;
  logic [SLOT_W-1:0]   alloc_slot;
  logic                alloc_ok;
  logic                scan_end;
  logic [WIDX_W-1:0]   raddr;
  logic                mem_we;
  logic [WIDX_W-1:0]   mem_waddr;
  logic [31:0]         mem_wdata;
  logic [31:0]         offset;
  logic [16:0]         div_ra;
  logic [16:0]         div_rb;
  logic [15:0]         div_rem_a;
  logic [15:0]         div_rem;
  logic                div_ga;
  logic                div_gb;
  logic [31:0]         div_dq;
  logic                quot_in_range;
  logic                out_load;

  assign live_cap = (CMP_W'(cap_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : CMP_W'(cap_q);
  assign cur_word = rd_vld_q ? rd_word_q : '0;

  always_comb begin
    zero_found = 1'b0;
    zero_bit   = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!cur_word[i]) begin
        zero_found = 1'b1;
        zero_bit   = 5'(i);
      end
    end
  end

  assign alloc_slot = {word_q, zero_bit};
  assign alloc_ok   = zero_found && (CMP_W'(alloc_slot) < live_cap);
  assign next_base  = CMP_W'({word_q, 5'b0}) + CMP_W'(WORD_BITS);
  assign scan_end   = (word_q == WIDX_W'(WORD_COUNT - 1)) || (next_base >= live_cap);

  assign raddr     = (state_q == S_F_RD) ? slot_q[SLOT_W-1:5] : word_q;
  assign mem_we    = ((state_q == S_A_CHK) && alloc_ok) || (state_q == S_F_WR);
  assign mem_waddr = (state_q == S_F_WR) ? slot_q[SLOT_W-1:5] : word_q;
  assign mem_wdata = (state_q == S_F_WR) ? (cur_word & ~(32'd1 << slot_q[4:0]))
                                         : (cur_word | (32'd1 << zero_bit));

  assign offset = s_axis_tdata - base_q;

  always_comb begin
    div_ra    = {rem_q, dq_q[31]};
    div_ga    = div_ra >= {1'b0, size_q};
    div_rem_a = div_ga ? 16'(div_ra - {1'b0, size_q}) : div_ra[15:0];
    div_rb    = {div_rem_a, dq_q[30]};
    div_gb    = div_rb >= {1'b0, size_q};
    div_rem   = div_gb ? 16'(div_rb - {1'b0, size_q}) : div_rb[15:0];
    div_dq    = {dq_q[29:0], div_ga, div_gb};
  end

  assign quot_in_range = dq_q < 32'(live_cap);
  assign out_load      = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_word_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cap_q      <= CAPACITY_RST;
      size_q     <= OBJ_SIZE_RST;
      base_q     <= BASE_RST;
      word_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY: cap_q  <= cfg_wdata_i[8:0];
          REG_OBJ_SIZE: size_q <= cfg_wdata_i[15:0];
          REG_BASE:     base_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (mem_we) begin
        word_vld_q[mem_waddr] <= 1'b1;
      end
      rd_vld_q <= word_vld_q[raddr];
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == CMD_ALLOC) begin
              word_q  <= '0;
              state_q <= S_A_RD;
            end else begin
              addr_q <= s_axis_tdata;
              cnt_q  <= '0;
              if (size_q == '0) begin
                dq_q    <= '0;
                rem_q   <= (offset != '0) ? 16'd1 : 16'd0;
                state_q <= S_F_RNG;
              end else begin
                dq_q    <= offset;
                rem_q   <= '0;
                state_q <= S_F_DIV;
              end
            end
          end
        end
        S_A_RD: state_q <= S_A_CHK;
        S_A_CHK: begin
          if (alloc_ok) begin
            slot_q  <= alloc_slot;
            state_q <= S_A_MUL;
          end else if (scan_end) begin
            res_status_q <= ST_FULL;
            res_index_q  <= '0;
            res_addr_q   <= '0;
            state_q      <= S_DONE;
          end else begin
            word_q  <= word_q + 1'b1;
            state_q <= S_A_RD;
          end
        end
        S_A_MUL: begin
          prod_q  <= PROD_W'(slot_q) * PROD_W'(size_q);
          state_q <= S_A_ADD;
        end
        S_A_ADD: begin
          res_status_q <= ST_OK;
          res_index_q  <= 8'(slot_q);
          res_addr_q   <= base_q + 32'(prod_q);
          state_q      <= S_DONE;
        end
        S_F_DIV: begin
          dq_q  <= div_dq;
          rem_q <= div_rem;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(DIV_ITER - 1)) begin
            state_q <= S_F_RNG;
          end
        end
        S_F_RNG: begin
          if (rem_q != '0) begin
            res_status_q <= ST_MISALIGNED;
            res_index_q  <= '0;
            res_addr_q   <= '0;
            state_q      <= S_DONE;
          end else if (!quot_in_range) begin
            res_status_q <= ST_RANGE;
            res_index_q  <= '0;
            res_addr_q   <= '0;
            state_q      <= S_DONE;
          end else begin
            slot_q  <= dq_q[SLOT_W-1:0];
            state_q <= S_F_RD;
          end
        end
        S_F_RD: state_q <= S_F_WR;
        S_F_WR: begin
          res_status_q <= ST_OK;
          res_index_q  <= 8'(slot_q);
          res_addr_q   <= addr_q;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_status_q <= res_status_q;
            out_index_q  <= res_index_q;
            out_addr_q   <= res_addr_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_addr_q, out_index_q, out_status_q};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  a_error_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |->
      (m_axis_tdata[9:2] == '0) && (m_axis_tdata[41:10] == '0))
    else $error("error result carries a nonzero index or address");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_F_DIV) && (cnt_q != 4'(DIV_ITER - 1)) |=>
      (state_q == S_F_DIV) && (cnt_q == $past(cnt_q) + 4'd1))
    else $error("divider left before its last step");

endmodule
